### sv/grid_layout_placer_unit_macros.svh
// Assertion macros used by the checker file glp_checker.sv
`ifndef GRID_LAYOUT_PLACER_UNIT_MACROS_SVH
`define GRID_LAYOUT_PLACER_UNIT_MACROS_SVH

// Clocked assertion, off during reset
`define GLP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion, checked during reset too
`define GLP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### sv/glp_pkg.sv
package glp_pkg;

  localparam int MAX_IMAGES = 64;
  localparam int IDX_W      = $clog2(MAX_IMAGES);
  localparam int CNT_W      = IDX_W + 1;
  localparam int DIM_W      = 12;
  localparam int PAD_W      = 8;
  localparam int POS_W      = 16;
  localparam int ACC_W      = 20;
  localparam int K_MAX      = 8;
  localparam int K_W        = 4;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] REG_PAD  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FLIP = 1'b1;

  typedef struct packed {
    logic store;
    logic start;
    logic rd;
    logic p1_step;
    logic p1_fin;
    logic p2_step;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic idx_last;
    logic out_last;
  } sts_t;

  function automatic logic [K_W-1:0] per_row(input logic [CNT_W-1:0] n);
    logic [K_W-1:0] k;
    k = K_W'(1);
    for (int j = 1; j <= K_MAX; j++) begin
      if (CNT_W'(j * j) < n) begin
        k = k + K_W'(1);
      end
    end
    return k;
  endfunction

endpackage

### sv/grid_layout_placer_unit.sv
// channel  | handshake                  | payload
// ---------+----------------------------+--------------------------------------------
// cfg      | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
// in       | in_valid_i / in_ready_o    | img_width_i, img_height_i, last_in_i
// out      | out_valid_o / out_ready_i  | pos_x_o, pos_y_o, canvas_width_o,
//          |                            | canvas_height_o, last_out_o
//
// Each image size is written to a size memory with separate write and read ports.
// After the last image, a first pass reads each stored size and steps the grid, and
// a finish state closes an unfinished last row; a second pass reads, computes and
// transfers each placement, held by output stalls. Memory reads are registered.
// Input ready is low meanwhile. Reset clears pad, flip, the image count and the
// controller; cfg_ready_o is always high.
module grid_layout_placer_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [glp_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [glp_pkg::PAD_W-1:0]       cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [glp_pkg::DIM_W-1:0]       img_width_i,
  input  logic [glp_pkg::DIM_W-1:0]       img_height_i,
  input  logic                            last_in_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [glp_pkg::POS_W-1:0]       pos_x_o,
  output logic [glp_pkg::POS_W-1:0]       pos_y_o,
  output logic [glp_pkg::POS_W-1:0]       canvas_width_o,
  output logic [glp_pkg::POS_W-1:0]       canvas_height_o,
  output logic                            last_out_o
);
  import glp_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  glp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .last_in_i   (last_in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  glp_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_valid_i && cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .img_width_i     (img_width_i),
    .img_height_i    (img_height_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .pos_x_o         (pos_x_o),
    .pos_y_o         (pos_y_o),
    .canvas_width_o  (canvas_width_o),
    .canvas_height_o (canvas_height_o),
    .last_out_o      (last_out_o)
  );

endmodule

### sv/glp_ctrl.sv
module glp_ctrl (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        last_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  input  glp_pkg::sts_t sts_i,
  output glp_pkg::cmd_t cmd_o
);
  import glp_pkg::*;

  localparam logic [2:0] S_LOAD  = 3'd0;
  localparam logic [2:0] S_P1RD  = 3'd1;
  localparam logic [2:0] S_P1PRC = 3'd2;
  localparam logic [2:0] S_P1FIN = 3'd3;
  localparam logic [2:0] S_P2RD  = 3'd4;
  localparam logic [2:0] S_P2LD  = 3'd5;
  localparam logic [2:0] S_P2OUT = 3'd6;

  logic [2:0] state_q, state_d;
  logic       in_xfer, out_xfer;

  assign in_ready_o  = (state_q == S_LOAD);
  assign out_valid_o = (state_q == S_P2OUT);
  assign in_xfer     = in_valid_i && in_ready_o;
  assign out_xfer    = out_valid_o && out_ready_i;

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    unique case (state_q)
      S_LOAD: begin
        cmd_o.store = in_xfer;
        if (in_xfer && last_in_i) begin
          cmd_o.start = 1'b1;
          state_d     = S_P1RD;
        end
      end
      S_P1RD: begin
        cmd_o.rd = 1'b1;
        state_d  = S_P1PRC;
      end
      S_P1PRC: begin
        cmd_o.p1_step = 1'b1;
        state_d       = sts_i.idx_last ? S_P1FIN : S_P1RD;
      end
      S_P1FIN: begin
        cmd_o.p1_fin = 1'b1;
        state_d      = S_P2RD;
      end
      S_P2RD: begin
        cmd_o.rd = 1'b1;
        state_d  = S_P2LD;
      end
      S_P2LD: begin
        cmd_o.p2_step = 1'b1;
        state_d       = S_P2OUT;
      end
      S_P2OUT: begin
        if (out_xfer) begin
          cmd_o.clear = sts_i.out_last;
          state_d     = sts_i.out_last ? S_LOAD : S_P2RD;
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### sv/glp_datapath.sv
module glp_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [glp_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [glp_pkg::PAD_W-1:0]       cfg_data_i,
  input  logic [glp_pkg::DIM_W-1:0]       img_width_i,
  input  logic [glp_pkg::DIM_W-1:0]       img_height_i,
  input  glp_pkg::cmd_t                   cmd_i,
  output glp_pkg::sts_t                   sts_o,
  output logic [glp_pkg::POS_W-1:0]       pos_x_o,
  output logic [glp_pkg::POS_W-1:0]       pos_y_o,
  output logic [glp_pkg::POS_W-1:0]       canvas_width_o,
  output logic [glp_pkg::POS_W-1:0]       canvas_height_o,
  output logic                            last_out_o
);
  import glp_pkg::*;

  logic [2*DIM_W-1:0] mem [MAX_IMAGES];
  logic [2*DIM_W-1:0] rdata_q;

  logic [PAD_W-1:0] pad_q;
  logic             flip_q;
  logic [CNT_W-1:0] count_q, count_d;
  logic [K_W-1:0]   k_q;
  logic [IDX_W-1:0] idx_q;
  logic [K_W-1:0]   col_q, col_d;
  logic [ACC_W-1:0] x_q, x_d, y_q, y_d, maxx_q, maxx_d;
  logic [DIM_W-1:0] rowh_q, rowh_d;
  logic [ACC_W-1:0] cw_q, ch_q;
  logic [POS_W-1:0] px_q, py_q;
  logic             last_q;

  logic [DIM_W-1:0] w, h, rowh_max;
  logic [ACC_W-1:0] pad_ext, x_step, y_row, fin_maxx, fin_y;
  logic [K_W-1:0]   col_inc;
  logic             wrap;
  logic [POS_W-1:0] oy;

  assign w       = rdata_q[2*DIM_W-1:DIM_W];
  assign h       = rdata_q[DIM_W-1:0];
  assign pad_ext = ACC_W'(pad_q);

  assign count_d = (count_q < CNT_W'(MAX_IMAGES)) ? count_q + CNT_W'(1) : count_q;

  assign sts_o.idx_last = ((CNT_W'(idx_q) + CNT_W'(1)) == count_q);
  assign sts_o.out_last = last_q;

  // one grid step, shared by both passes
  assign x_step   = x_q + ACC_W'(w) + pad_ext;
  assign rowh_max = (h > rowh_q) ? h : rowh_q;
  assign col_inc  = col_q + K_W'(1);
  assign wrap     = (col_inc >= k_q);
  assign y_row    = y_q + ACC_W'(rowh_max) + pad_ext;

  always_comb begin
    if (wrap) begin
      x_d    = pad_ext;
      y_d    = y_row;
      rowh_d = '0;
      col_d  = '0;
      maxx_d = (x_step > maxx_q) ? x_step : maxx_q;
    end else begin
      x_d    = x_step;
      y_d    = y_q;
      rowh_d = rowh_max;
      col_d  = col_inc;
      maxx_d = maxx_q;
    end
  end

  // close an unfinished row
  always_comb begin
    if (col_q != '0) begin
      fin_maxx = (x_q > maxx_q) ? x_q : maxx_q;
      fin_y    = y_q + ACC_W'(rowh_q) + pad_ext;
    end else begin
      fin_maxx = maxx_q;
      fin_y    = y_q;
    end
  end

  assign oy = flip_q ? (ch_q[POS_W-1:0] - (y_q[POS_W-1:0] + POS_W'(h))) : y_q[POS_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pad_q   <= '0;
      flip_q  <= 1'b0;
      count_q <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_PAD:  pad_q  <= cfg_data_i;
          REG_FLIP: flip_q <= cfg_data_i[0];
          default:  pad_q  <= pad_q;
        endcase
      end
      if (cmd_i.clear) begin
        count_q <= '0;
      end else if (cmd_i.store) begin
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.store && (count_q < CNT_W'(MAX_IMAGES))) begin
      mem[count_q[IDX_W-1:0]] <= {img_width_i, img_height_i};
    end
    if (cmd_i.rd) begin
      rdata_q <= mem[idx_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      k_q    <= per_row(count_d);
      idx_q  <= '0;
      x_q    <= pad_ext;
      y_q    <= pad_ext;
      col_q  <= '0;
      rowh_q <= '0;
      maxx_q <= '0;
    end else if (cmd_i.p1_step) begin
      idx_q  <= idx_q + IDX_W'(1);
      x_q    <= x_d;
      y_q    <= y_d;
      col_q  <= col_d;
      rowh_q <= rowh_d;
      maxx_q <= maxx_d;
    end else if (cmd_i.p1_fin) begin
      cw_q   <= fin_maxx;
      ch_q   <= fin_y;
      idx_q  <= '0;
      x_q    <= pad_ext;
      y_q    <= pad_ext;
      col_q  <= '0;
      rowh_q <= '0;
    end else if (cmd_i.p2_step) begin
      px_q   <= x_q[POS_W-1:0];
      py_q   <= oy;
      last_q <= sts_o.idx_last;
      idx_q  <= idx_q + IDX_W'(1);
      x_q    <= x_d;
      y_q    <= y_d;
      col_q  <= col_d;
      rowh_q <= rowh_d;
    end
  end

  assign pos_x_o         = px_q;
  assign pos_y_o         = py_q;
  assign canvas_width_o  = cw_q[POS_W-1:0];
  assign canvas_height_o = ch_q[POS_W-1:0];
  assign last_out_o      = last_q;

endmodule

### sv/glp_checker.sv
`include "grid_layout_placer_unit_macros.svh"

module glp_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            cfg_valid_i,
  input logic                            cfg_ready_o,
  input logic [glp_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input logic [glp_pkg::PAD_W-1:0]       cfg_data_i,
  input logic                            in_valid_i,
  input logic                            in_ready_o,
  input logic [glp_pkg::DIM_W-1:0]       img_width_i,
  input logic [glp_pkg::DIM_W-1:0]       img_height_i,
  input logic                            last_in_i,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic [glp_pkg::POS_W-1:0]       pos_x_o,
  input logic [glp_pkg::POS_W-1:0]       pos_y_o,
  input logic [glp_pkg::POS_W-1:0]       canvas_width_o,
  input logic [glp_pkg::POS_W-1:0]       canvas_height_o,
  input logic                            last_out_o
);

  `GLP_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(pos_x_o) && $stable(pos_y_o) && $stable(last_out_o), "output dropped or changed while stalled")

  `GLP_ASSERT_ALWAYS(a_one_side, !(in_ready_o && out_valid_o), "input ready while a result is pending")

  `GLP_ASSERT(a_canvas_const, out_valid_o && out_ready_i && !last_out_o |=> $stable(canvas_width_o) && $stable(canvas_height_o), "canvas size changed within a set")

  `GLP_ASSERT(a_reload, out_valid_o && out_ready_i && last_out_o |=> in_ready_o, "no return to loading after the final result")

  `GLP_ASSERT(a_layout_start, in_valid_i && in_ready_o && last_in_i |=> !in_ready_o && !out_valid_o, "layout did not start after the final image")

endmodule

bind grid_layout_placer_unit glp_checker u_glp_checker (.*);

### verif/glp_placement_checker.sv
module glp_placement_checker
  import glp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  input  logic             cfg_ready_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [PAD_W-1:0] cfg_data_i,
  input  logic             in_valid_i,
  input  logic             in_ready_i,
  input  logic [DIM_W-1:0] img_width_i,
  input  logic [DIM_W-1:0] img_height_i,
  input  logic             last_in_i,
  input  logic             out_valid_i,
  input  logic             out_ready_i,
  input  logic [POS_W-1:0] pos_x_i,
  input  logic [POS_W-1:0] pos_y_i,
  input  logic [POS_W-1:0] canvas_width_i,
  input  logic [POS_W-1:0] canvas_height_i,
  input  logic             last_out_i,
  output int               mismatches_o,
  output int               pending_o
);

  typedef struct packed {
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [POS_W-1:0] canvas_width;
    logic [POS_W-1:0] canvas_height;
    logic             last_out;
  } placement_t;

  placement_t       placements_q[$];
  placement_t       got;
  placement_t       want;
  logic [PAD_W-1:0] pad_q;
  logic             flip_q;
  logic [DIM_W-1:0] widths[MAX_IMAGES];
  logic [DIM_W-1:0] heights[MAX_IMAGES];
  int unsigned      stored;
  int unsigned      per_row_k;
  int unsigned      cur_x;
  int unsigned      cur_y;
  int unsigned      row_h;
  int unsigned      col;
  int unsigned      max_x;
  int unsigned      out_y;
  int unsigned      xs[MAX_IMAGES];
  int unsigned      ys[MAX_IMAGES];
  int               mismatches;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pad_q        = '0;
      flip_q       = 1'b0;
      stored       = 0;
      mismatches   = 0;
      placements_q.delete();
      mismatches_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == REG_PAD) begin
          pad_q = cfg_data_i;
        end else if (cfg_index_i == REG_FLIP) begin
          flip_q = cfg_data_i[0];
        end
      end

      if (out_valid_i && out_ready_i) begin
        got = '{pos_x_i, pos_y_i, canvas_width_i, canvas_height_i, last_out_i};
        if (placements_q.size() == 0) begin
          $error("unexpected result: pos_x %0d pos_y %0d", pos_x_i, pos_y_i);
          mismatches++;
        end else begin
          want = placements_q.pop_front();
          if (got.pos_x !== want.pos_x) begin
            $error("pos_x: expected %0d, actual %0d", want.pos_x, got.pos_x);
            mismatches++;
          end
          if (got.pos_y !== want.pos_y) begin
            $error("pos_y: expected %0d, actual %0d", want.pos_y, got.pos_y);
            mismatches++;
          end
          if (got.canvas_width !== want.canvas_width) begin
            $error("canvas_width: expected %0d, actual %0d", want.canvas_width,
                   got.canvas_width);
            mismatches++;
          end
          if (got.canvas_height !== want.canvas_height) begin
            $error("canvas_height: expected %0d, actual %0d", want.canvas_height,
                   got.canvas_height);
            mismatches++;
          end
          if (got.last_out !== want.last_out) begin
            $error("last_out: expected %0d, actual %0d", want.last_out, got.last_out);
            mismatches++;
          end
        end
      end

      if (in_valid_i && in_ready_i) begin
        // drop sizes once the store is full
        if (stored < MAX_IMAGES) begin
          widths[stored]  = img_width_i;
          heights[stored] = img_height_i;
          stored++;
        end
        if (last_in_i) begin
          per_row_k = 1;
          while (per_row_k * per_row_k < stored) per_row_k++;
          cur_x = pad_q;
          cur_y = pad_q;
          row_h = 0;
          col   = 0;
          max_x = 0;
          for (int i = 0; i < stored; i++) begin
            xs[i] = cur_x;
            ys[i] = cur_y;
            cur_x = cur_x + widths[i] + pad_q;
            if (heights[i] > row_h) row_h = heights[i];
            col++;
            if (col >= per_row_k) begin
              if (cur_x > max_x) max_x = cur_x;
              col   = 0;
              cur_x = pad_q;
              cur_y = cur_y + row_h + pad_q;
              row_h = 0;
            end
          end
          if (col != 0) begin
            if (cur_x > max_x) max_x = cur_x;
            cur_y = cur_y + row_h + pad_q;
          end
          for (int i = 0; i < stored; i++) begin
            out_y = flip_q ? cur_y - (ys[i] + heights[i]) : ys[i];
            placements_q.push_back('{xs[i][POS_W-1:0], out_y[POS_W-1:0],
                                     max_x[POS_W-1:0], cur_y[POS_W-1:0],
                                     (i + 1 == stored)});
          end
          stored = 0;
        end
      end

      mismatches_o <= mismatches;
      pending_o    <= placements_q.size();
    end
  end

endmodule

### verif/tb_grid_layout_placer_unit.sv
module tb_grid_layout_placer_unit;
  import glp_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE      = 10;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni;
  logic                 cfg_valid_i   = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i   = '0;
  logic [PAD_W-1:0]     cfg_data_i    = '0;
  logic                 in_valid_i    = 1'b0;
  logic                 in_ready_o;
  logic [DIM_W-1:0]     img_width_i   = '0;
  logic [DIM_W-1:0]     img_height_i  = '0;
  logic                 last_in_i     = 1'b0;
  logic                 out_valid_o;
  logic                 out_ready_i   = 1'b0;
  logic [POS_W-1:0]     pos_x_o;
  logic [POS_W-1:0]     pos_y_o;
  logic [POS_W-1:0]     canvas_width_o;
  logic [POS_W-1:0]     canvas_height_o;
  logic                 last_out_o;

  int   mismatches;
  int   pending;
  int   cycle_count  = 0;
  int   images_sent  = 0;
  int   phase        = 0;
  logic calm         = 1'b0;
  logic hold_req     = 1'b0;

  grid_layout_placer_unit uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .img_width_i    (img_width_i),
    .img_height_i   (img_height_i),
    .last_in_i      (last_in_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .pos_x_o        (pos_x_o),
    .pos_y_o        (pos_y_o),
    .canvas_width_o (canvas_width_o),
    .canvas_height_o(canvas_height_o),
    .last_out_o     (last_out_o)
  );

  glp_placement_checker placement_chk (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_i    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .img_width_i    (img_width_i),
    .img_height_i   (img_height_i),
    .last_in_i      (last_in_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .pos_x_i        (pos_x_o),
    .pos_y_i        (pos_y_o),
    .canvas_width_i (canvas_width_o),
    .canvas_height_i(canvas_height_o),
    .last_out_i     (last_out_o),
    .mismatches_o   (mismatches),
    .pending_o      (pending)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_grid_layout_placer_unit: done, errors");
      $finish;
    end
  end

  function automatic int pick_idle();
    int r;
    r = $urandom_range(99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(15, 50);
  endfunction

  function automatic logic [DIM_W-1:0] pick_dim();
    int r;
    r = $urandom_range(99);
    if (r < 10) return '0;
    if (r < 20) return '1;
    if (r < 55) return DIM_W'($urandom_range(64));
    return DIM_W'($urandom);
  endfunction

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        int idle;
        idle = pick_idle();
        if (idle == 0) begin
          out_ready_i <= 1'b1;
        end else begin
          out_ready_i <= 1'b0;
          repeat (idle - 1) @(posedge clk_i);
        end
      end
    end
  end

  task automatic push_image(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                            input logic last);
    int gap;
    gap = pick_idle();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    img_width_i  <= w;
    img_height_i <= h;
    last_in_i    <= last;
    do @(posedge clk_i); while (!in_ready_o);
    images_sent++;
  endtask

  task automatic push_random_set(input int n);
    for (int i = 0; i < n; i++) begin
      push_image(pick_dim(), pick_dim(), (i == n - 1));
    end
  endtask

  // hold input until every placement has come back, then let the block settle
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_layout_cfg(input logic [PAD_W-1:0] pad, input logic flip);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= REG_PAD;
    cfg_data_i  <= pad;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_index_i <= REG_FLIP;
    cfg_data_i  <= {7'($urandom), flip};
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    int r;
    int n;
    logic [PAD_W-1:0] pad;
    rst_ni <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // reset settings: single images at the size extremes
    push_image('0, '0, 1'b1);
    push_image('1, '1, 1'b1);
    drain();

    write_layout_cfg(8'hff, 1'b1);
    push_image('1, '0, 1'b0);
    push_image('0, '1, 1'b0);
    push_image('1, '1, 1'b0);
    push_image(12'd1, 12'd1, 1'b1);
    push_image(12'd7, 12'd300, 1'b0);
    push_image('1, 12'd2, 1'b0);
    push_image(12'h555, 12'haaa, 1'b0);
    push_image(12'haaa, 12'h555, 1'b0);
    push_image('0, '1, 1'b1);
    drain();

    write_layout_cfg('0, 1'b0);
    for (int i = 0; i < 9; i++) begin
      push_image('1, DIM_W'(i * 400), (i == 8));
    end
    drain();

    images_sent = 0;
    while (images_sent < 250) begin
      phase++;
      r = $urandom_range(99);
      pad = (r < 25) ? '0 : (r < 50) ? '1 : PAD_W'($urandom);
      write_layout_cfg(pad, 1'($urandom));
      calm = ($urandom_range(99) < 20);
      if (phase == 1) begin
        calm     = 1'b0;
        hold_req = 1'b1;
        repeat (3) push_random_set($urandom_range(1, 9));
      end else if (phase == 2) begin
        push_random_set(MAX_IMAGES);
      end else if (phase == 3) begin
        // two sizes past a full store, the final one marked last
        push_random_set(MAX_IMAGES + 2);
      end else begin
        repeat ($urandom_range(1, 4)) begin
          r = $urandom_range(99);
          n = (r < 70) ? $urandom_range(1, 9) : $urandom_range(10, 40);
          if (images_sent < 250) begin
            push_random_set(n);
          end
        end
      end
      drain();
    end

    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (50) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("tb_grid_layout_placer_unit: done, clean");
    end else begin
      $display("tb_grid_layout_placer_unit: done, errors");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+sv
sv/glp_pkg.sv
sv/glp_ctrl.sv
sv/glp_datapath.sv
sv/grid_layout_placer_unit.sv
sv/glp_checker.sv
verif/glp_placement_checker.sv
verif/tb_grid_layout_placer_unit.sv
